// ===== design/mrgsort_pkg.sv =====
// ----------------------------------------------------------------------------
// mrgsort_pkg
// Shared defaults and controller/datapath interface types for the merge sorter.
// ----------------------------------------------------------------------------
package mrgsort_pkg;

    localparam int DEFAULT_DEPTH    = 64;
    localparam int DEFAULT_KEY_BITS = 32;
    localparam int DEFAULT_TAG_BITS = 16;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic run_init;
        logic merge_step;
        logic pass_end;
        logic out_init;
        logic out_step;
        logic clear;
    } mrgsort_cmd_t;

    typedef struct packed {
        logic more_passes;
        logic pass_last;
        logic out_last;
    } mrgsort_status_t;

endpackage

// ===== design/mrgsort_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrgsort_ctrl
// Sequencer: load, merge passes with a read bubble before each, then unload.
// ----------------------------------------------------------------------------
module mrgsort_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tlast,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  mrgsort_pkg::mrgsort_status_t status,
    output mrgsort_pkg::mrgsort_cmd_t    cmd
);
    import mrgsort_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PREP,
        ST_MERGE,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                if (status.more_passes) begin
                    cmd.run_init = 1'b1;
                    state_next   = ST_MERGE;
                end else begin
                    cmd.out_init = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_MERGE: begin
                cmd.merge_step = 1'b1;
                if (status.pass_last) begin
                    cmd.pass_end = 1'b1;
                    state_next   = ST_PREP;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    cmd.out_step = 1'b1;
                    if (status.out_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== design/mrgsort_dp.sv =====
// ----------------------------------------------------------------------------
// mrgsort_dp
// Ping-pong buffers, run indexes, key compare and the direction register.
// ----------------------------------------------------------------------------
module mrgsort_dp #(
    parameter int DEPTH    = mrgsort_pkg::DEFAULT_DEPTH,
    parameter int KEY_BITS = mrgsort_pkg::DEFAULT_KEY_BITS,
    parameter int TAG_BITS = mrgsort_pkg::DEFAULT_TAG_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic [KEY_BITS+TAG_BITS-1:0]    in_entry,
    input  mrgsort_pkg::mrgsort_cmd_t       cmd,
    output mrgsort_pkg::mrgsort_status_t    status,
    output logic [KEY_BITS+TAG_BITS-1:0]    out_entry,
    output logic                            out_final,
    output logic                            out_overflow
);
    import mrgsort_pkg::*;

    localparam int DATA_W = KEY_BITS + TAG_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 2;

    logic [DATA_W-1:0] first_mem  [DEPTH];
    logic [DATA_W-1:0] second_mem [DEPTH];

    logic [DATA_W-1:0] first_a_reg, first_b_reg, second_a_reg, second_b_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             desc_reg;
    logic             par_reg, par_next;
    logic [SUM_W-1:0] w_reg, w_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;

    logic [DATA_W-1:0]   left_ent, right_ent, win_ent, wr_data;
    logic [KEY_BITS-1:0] left_key, right_key;
    logic                take_left, full, run_done;
    logic                we_first, we_second;
    logic [AW-1:0]       wr_addr;
    logic [SUM_W-1:0]    n_ext, hi_ext;

    function automatic logic [CNT_W-1:0] clip(input logic [SUM_W-1:0] v,
                                              input logic [SUM_W-1:0] lim);
        clip = (v > lim) ? lim[CNT_W-1:0] : v[CNT_W-1:0];
    endfunction

    assign n_ext     = SUM_W'(count_reg);
    assign hi_ext    = SUM_W'(hi_reg);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign left_ent  = par_reg ? second_a_reg : first_a_reg;
    assign right_ent = par_reg ? second_b_reg : first_b_reg;
    assign left_key  = left_ent[KEY_BITS-1:0];
    assign right_key = right_ent[KEY_BITS-1:0];
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) ||
                        (desc_reg ? (right_key < left_key) : (right_key > left_key)));
    assign win_ent   = take_left ? left_ent : right_ent;
    assign run_done  = ((k_reg + CNT_W'(1)) == hi_reg);

    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        par_next     = par_reg;
        w_next       = w_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        if (cmd.load) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.sort_init) begin
            w_next   = SUM_W'(1);
            par_next = 1'b0;
        end
        if (cmd.run_init) begin
            i_next   = '0;
            k_next   = '0;
            mid_next = clip(w_reg, n_ext);
            j_next   = mid_next;
            hi_next  = clip(w_reg << 1, n_ext);
        end
        if (cmd.merge_step) begin
            k_next = k_reg + CNT_W'(1);
            if (run_done) begin
                i_next   = hi_reg;
                mid_next = clip(hi_ext + w_reg, n_ext);
                j_next   = mid_next;
                hi_next  = clip(hi_ext + (w_reg << 1), n_ext);
            end else if (take_left) begin
                i_next = i_reg + CNT_W'(1);
            end else begin
                j_next = j_reg + CNT_W'(1);
            end
        end
        if (cmd.pass_end) begin
            par_next = !par_reg;
            w_next   = w_reg << 1;
        end
        if (cmd.out_init) begin
            i_next = '0;
        end
        if (cmd.out_step) begin
            i_next = i_reg + CNT_W'(1);
        end
        if (cmd.clear) begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            desc_reg    <= 1'b0;
        end else begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            if (cfg_wr_en) begin
                desc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        par_reg <= par_next;
        w_reg   <= w_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
    end

    // write side: loads go to the first buffer, merges to the one not being read
    assign we_first  = (cmd.load && !full) || (cmd.merge_step && par_reg);
    assign we_second = cmd.merge_step && !par_reg;
    assign wr_addr   = cmd.load ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wr_data   = cmd.load ? in_entry : win_ent;

    // read ports track next indexes so heads are ready in the cycle of use
    always_ff @(posedge aclk) begin
        if (we_first) begin
            first_mem[wr_addr] <= wr_data;
        end
        first_a_reg <= first_mem[i_next[AW-1:0]];
        first_b_reg <= first_mem[j_next[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (we_second) begin
            second_mem[wr_addr] <= wr_data;
        end
        second_a_reg <= second_mem[i_next[AW-1:0]];
        second_b_reg <= second_mem[j_next[AW-1:0]];
    end

    assign status.more_passes = (w_reg < n_ext);
    assign status.pass_last   = ((k_reg + CNT_W'(1)) == count_reg);
    assign status.out_last    = ((i_reg + CNT_W'(1)) == count_reg);

    assign out_entry    = left_ent;
    assign out_final    = status.out_last;
    assign out_overflow = dropped_reg;

endmodule

// ===== design/bottom_up_merge_sort.sv =====
// ----------------------------------------------------------------------------
// bottom_up_merge_sort
// Loads a set of key/tag items, merge-sorts it in ping-pong buffers and streams it out.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  s_*     | in        | tdata {tag, key}, tlast = last
//  m_*     | out       | tdata {sorted_tag, sorted_key}, tlast = final_res,
//          |           | tuser = overflow
//  cfg_*   | in        | descending
//
//  Load takes one item per cycle. Sorting n items takes ceil(log2 n) passes
//  (one compare per cycle, one read bubble per pass), then results leave one
//  per cycle while m_tready is high. Synchronous active-low reset returns to
//  loading with an empty set. A stalled output holds its item; no input is
//  taken until the set is out.
// ----------------------------------------------------------------------------
module bottom_up_merge_sort #(
    parameter int DEPTH    = mrgsort_pkg::DEFAULT_DEPTH,
    parameter int KEY_BITS = mrgsort_pkg::DEFAULT_KEY_BITS,
    parameter int TAG_BITS = mrgsort_pkg::DEFAULT_TAG_BITS,
    localparam int TDATA_W = ((KEY_BITS + TAG_BITS + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // key, tag, zero fill
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // sorted_key, sorted_tag, zero fill
    output logic               m_tlast,
    output logic               m_tuser    // overflow
);
    import mrgsort_pkg::*;

    localparam int DATA_W = KEY_BITS + TAG_BITS;

    mrgsort_cmd_t      cmd;
    mrgsort_status_t   status;
    logic [DATA_W-1:0] out_entry;

    mrgsort_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mrgsort_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_entry     (s_tdata[DATA_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .out_entry    (out_entry),
        .out_final    (m_tlast),
        .out_overflow (m_tuser)
    );

    assign m_tdata = TDATA_W'(out_entry);

endmodule

// ===== design/mrgsort_chk.sv =====
// ----------------------------------------------------------------------------
// mrgsort_chk
// Port-level checks on the load/sort/unload sequence of the merge sorter.
// ----------------------------------------------------------------------------
module mrgsort_chk (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic s_tlast,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast,
    input logic m_tuser
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_phase_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("load and unload overlap");

    a_sort_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still taken after end of set");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("no return to load after final item");

    a_ovf_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && $stable(m_tuser)))
        else $error("overflow flag changed within a set");

endmodule

bind bottom_up_merge_sort mrgsort_chk u_mrgsort_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_bottom_up_merge_sort.sv =====
// ----------------------------------------------------------------------------
// tb_bottom_up_merge_sort
// Self-checking bench for the bottom-up merge sorter. Sets of key/tag items
// are streamed in under random source and sink gaps. A behavioral merge sort
// with the same tie rule (right-hand run wins on equal keys) predicts every
// sorted item, final flag and overflow flag. The run covers both sort
// directions, single-item, full and overflowing sets, and a long sink stall.
// ----------------------------------------------------------------------------
module tb_bottom_up_merge_sort;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_N     = mrgsort_pkg::DEFAULT_DEPTH;
    localparam int KEY_W       = mrgsort_pkg::DEFAULT_KEY_BITS;
    localparam int TAG_W       = mrgsort_pkg::DEFAULT_TAG_BITS;
    localparam int DATA_W      = ((KEY_W + TAG_W + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 480;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit [KEY_W-1:0] key;
        bit [TAG_W-1:0] tag;
        bit             last;
    } load_item_t;

    typedef struct {
        bit [KEY_W-1:0] key;
        bit [TAG_W-1:0] tag;
        bit             final_res;
        bit             overflow;
    } sorted_item_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic              cfg_wr_data = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata     = '0;   // key, tag, zero fill
    logic              s_tlast     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [DATA_W-1:0] m_tdata;            // sorted_key, sorted_tag, zero fill
    logic              m_tlast;
    logic              m_tuser;            // overflow

    load_item_t   send_items[$];
    sorted_item_t sorted_exp[$];

    bit             sort_desc;
    bit [KEY_W-1:0] load_key [DEPTH_N];
    bit [TAG_W-1:0] load_tag [DEPTH_N];
    bit [KEY_W-1:0] run_key  [DEPTH_N];
    bit [TAG_W-1:0] run_tag  [DEPTH_N];
    bit [KEY_W-1:0] mrg_key  [DEPTH_N];
    bit [TAG_W-1:0] mrg_tag  [DEPTH_N];
    int             load_cnt;
    bit             load_dropped;

    bit no_idle;
    int hold_seq;
    int hold_seen;
    int hold_cnt;
    int src_gap;
    int snk_gap;
    int err_count;
    int set_count;
    int ovf_sets;
    int items_sent;
    int results_seen;
    int cycle_count;

    bottom_up_merge_sort uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got,
                                   longint unsigned want);
        $display("MISMATCH result %0d %s: got %h expected %h",
                 results_seen, what, got, want);
        err_count++;
    endtask

    // merge passes of doubling width; on equal keys the right run goes first
    task automatic merge_sort_set();
        sorted_item_t res;
        int n, w, base, mid, hi, i, j, k;
        n = load_cnt;
        for (k = 0; k < n; k++) begin
            run_key[k] = load_key[k];
            run_tag[k] = load_tag[k];
        end
        for (w = 1; w < n; w = w * 2) begin
            for (base = 0; base < n; base += 2 * w) begin
                mid = (base + w > n) ? n : base + w;
                hi  = (base + 2 * w > n) ? n : base + 2 * w;
                i = base;
                j = mid;
                k = base;
                while (i < mid || j < hi) begin
                    if (j >= hi || (i < mid && (sort_desc ? run_key[j] < run_key[i]
                                                          : run_key[j] > run_key[i]))) begin
                        mrg_key[k] = run_key[i];
                        mrg_tag[k] = run_tag[i];
                        i++;
                    end else begin
                        mrg_key[k] = run_key[j];
                        mrg_tag[k] = run_tag[j];
                        j++;
                    end
                    k++;
                end
            end
            for (k = 0; k < n; k++) begin
                run_key[k] = mrg_key[k];
                run_tag[k] = mrg_tag[k];
            end
        end
        for (k = 0; k < n; k++) begin
            res.key       = run_key[k];
            res.tag       = run_tag[k];
            res.final_res = (k == n - 1);
            res.overflow  = load_dropped;
            sorted_exp.push_back(res);
        end
        set_count++;
        if (load_dropped) ovf_sets++;
        load_cnt     = 0;
        load_dropped = 1'b0;
    endtask

    // source side
    always @(posedge aclk) begin
        load_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (send_items.size() > 0) begin
                it = send_items.pop_front();
                s_tdata  <= DATA_W'({it.tag, it.key});
                s_tlast  <= it.last;
                s_tvalid <= 1'b1;
                src_gap = gap_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // input acceptance feeds the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            items_sent++;
            if (load_cnt < DEPTH_N) begin
                load_key[load_cnt] = s_tdata[KEY_W-1:0];
                load_tag[load_cnt] = s_tdata[KEY_W +: TAG_W];
                load_cnt++;
            end else begin
                load_dropped = 1'b1;
            end
            if (s_tlast) merge_sort_set();
        end
    end

    // sink side
    always @(posedge aclk) begin
        int k;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_gap  = 0;
            hold_cnt = 0;
        end else if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_cnt  = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else begin
            k = gap_len();
            if (k > 0) begin
                snk_gap = k - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        sorted_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sorted_exp.size() == 0) begin
                report_mismatch("unexpected item", 64'(m_tdata), 64'd0);
            end else begin
                want = sorted_exp.pop_front();
                if (m_tdata[KEY_W-1:0] !== want.key)
                    report_mismatch("sorted_key", 64'(m_tdata[KEY_W-1:0]), 64'(want.key));
                if (m_tdata[KEY_W +: TAG_W] !== want.tag)
                    report_mismatch("sorted_tag", 64'(m_tdata[KEY_W +: TAG_W]),
                                    64'(want.tag));
                if (m_tlast !== want.final_res)
                    report_mismatch("final_res", 64'(m_tlast), 64'(want.final_res));
                if (m_tuser !== want.overflow)
                    report_mismatch("overflow", 64'(m_tuser), 64'(want.overflow));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycle_count, sorted_exp.size());
            $display("bottom_up_merge_sort test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (send_items.size() > 0 || s_tvalid || sorted_exp.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_dir(bit desc);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= desc;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sort_desc = desc;
    endtask

    task automatic push_item(bit [KEY_W-1:0] key, bit [TAG_W-1:0] tag, bit last);
        load_item_t it;
        it.key  = key;
        it.tag  = tag;
        it.last = last;
        send_items.push_back(it);
    endtask

    function automatic bit [KEY_W-1:0] pick_key(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 7);
            default: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, {(KEY_W-1){1'b0}}};
                    3: return {1'b0, {(KEY_W-1){1'b1}}};
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic push_set(int n);
        int mode;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            push_item(pick_key(mode), TAG_W'($urandom), i == n - 1);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 16);
        if (r < 90) return $urandom_range(17, 63);
        if (r < 95) return DEPTH_N;
        return $urandom_range(DEPTH_N + 1, DEPTH_N + 8);
    endfunction

    initial begin
        int rand_sent;
        int n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        write_dir(1'b0);

        // directed: single-item sets at the extremes, ties, key extremes
        push_item('1, '1, 1'b1);
        push_item('0, '0, 1'b1);
        for (int i = 1; i <= 5; i++)
            push_item(32'd7, TAG_W'(i), i == 5);
        push_item(32'h0000_0000, 16'h0001, 1'b0);
        push_item(32'hFFFF_FFFF, 16'h0002, 1'b0);
        push_item(32'h0000_0001, 16'h0003, 1'b0);
        push_item(32'h7FFF_FFFF, 16'h0004, 1'b0);
        push_item(32'h8000_0000, 16'h0005, 1'b1);
        wait_drained();

        write_dir(1'b1);
        push_item(32'h0000_0005, 16'hAAAA, 1'b0);
        push_item(32'hFFFF_FFFF, 16'h5555, 1'b0);
        push_item(32'h0000_0005, 16'h1234, 1'b0);
        push_item(32'h0000_0000, 16'hFFFF, 1'b0);
        push_item(32'hFFFF_FFFF, 16'h0000, 1'b0);
        push_item(32'h0000_0005, 16'h8001, 1'b1);
        push_item(32'h1234_5678, 16'h4321, 1'b1);
        wait_drained();

        // random sets, direction rewritten every phase
        rand_sent = 0;
        for (int p = 0; rand_sent < RAND_ITEMS; p++) begin
            write_dir(p == 0 ? 1'b0 : p == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            no_idle = (p % 5 == 3);
            if (p == 2) begin
                hold_seq++;
                for (int s = 0; s < 3; s++) begin
                    n = $urandom_range(10, 20);
                    push_set(n);
                    rand_sent += n;
                end
            end else if (p == 1) begin
                push_set(DEPTH_N);
                push_set(DEPTH_N + 6);
                push_set(DEPTH_N + 1);
                rand_sent += 3 * DEPTH_N + 7;
            end else begin
                for (int s = $urandom_range(1, 4); s > 0; s--) begin
                    n = pick_len();
                    push_set(n);
                    rand_sent += n;
                end
            end
            wait_drained();
        end

        $display("sent %0d items in %0d sets (%0d overflowing), checked %0d sorted items",
                 items_sent, set_count, ovf_sets, results_seen);
        $display("both sort directions, ties, single, full and oversize sets, long sink stall");
        if (err_count == 0) begin
            $display("bottom_up_merge_sort test passed");
        end else begin
            $display("bottom_up_merge_sort test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mrgsort_pkg.sv
design/mrgsort_ctrl.sv
design/mrgsort_dp.sv
design/bottom_up_merge_sort.sv
design/mrgsort_chk.sv
tb/tb_bottom_up_merge_sort.sv
